### design/ldfc_pkg.sv
// Package for the LED dimmer fade controller: request types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package ldfc_pkg;

    localparam int unsigned DUTY_W = 8;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned CMD_W  = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX       = {DUTY_W{1'b1}};
    localparam logic [TICK_W-1:0] STEP_TICKS_RST = TICK_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_ON     = 3'd1,
        CMD_OFF    = 3'd2,
        CMD_TOGGLE = 3'd3,
        CMD_SET    = 3'd4,
        CMD_ADJUST = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        RAMP_IDLE  = 2'd0,
        RAMP_ON    = 2'd1,
        RAMP_OFF   = 2'd2,
        RAMP_LEVEL = 2'd3
    } t_ramp_mode;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [DUTY_W-1:0]        level;
        logic signed [DUTY_W-1:0] delta;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              lamp_on;
        logic              busy_res;
        logic              onoff_event;
        logic              level_event;
        logic [DUTY_W-1:0] stored_level;
    } t_out;

endpackage

`default_nettype wire

### design/led_dimmer_fade_controller_core.sv
// LED dimmer fade controller: request decode, fade stepping and result register.
//
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_ready     i_in_data  (t_in)
//  out       result     o_out_valid / i_out_ready   o_out_data (t_out)
//  cfg       write      i_cfg_valid / o_cfg_ready   i_cfg_data (step_ticks)
//
// One request per cycle while the output is not stalled; each request gives one
// result (input register, then state update into the result register).
// The lamp state registers and the result register are written in the same cycle.
// A stalled output holds both stages; o_in_ready drops only when both are full.
// Synchronous active-low reset: lamp off, duty and level zero, step_ticks one.
`timescale 1ns / 1ps
`default_nettype none

module led_dimmer_fade_controller_core
    import ldfc_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output t_out              o_out_data,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [TICK_W-1:0]  i_cfg_data
);

    // input stage
    logic              r_in_valid;
    t_in               r_in_data;
    // result stage
    logic              r_out_valid;
    t_out              r_out_data;
    // lamp state
    logic [TICK_W-1:0] r_step_ticks;
    logic [DUTY_W-1:0] r_duty;
    logic [DUTY_W-1:0] r_level;
    logic              r_is_on;
    logic [DUTY_W-1:0] r_target;
    t_ramp_mode        r_mode;
    logic [TICK_W-1:0] r_tick;

    logic [DUTY_W-1:0] n_duty;
    logic [DUTY_W-1:0] n_level;
    logic              n_is_on;
    logic [DUTY_W-1:0] n_target;
    t_ramp_mode        n_mode;
    logic [TICK_W-1:0] n_tick;
    logic              n_ev_onoff;
    logic              n_ev_level;

    logic              advance;
    logic              take_in;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign take_in     = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        logic [TICK_W-1:0]   limit;
        logic [TICK_W-1:0]   cnt;
        logic [DUTY_W-1:0]   on_lvl;
        logic signed [DUTY_W+1:0] sum;
        logic                go_on;
        logic                go_off;
        logic                check;

        n_duty     = r_duty;
        n_level    = r_level;
        n_is_on    = r_is_on;
        n_target   = r_target;
        n_mode     = r_mode;
        n_tick     = r_tick;
        n_ev_onoff = 1'b0;
        n_ev_level = 1'b0;
        check      = 1'b0;
        go_on      = 1'b0;
        go_off     = 1'b0;
        limit      = (r_step_ticks == '0) ? TICK_W'(1) : r_step_ticks;
        cnt        = r_tick + TICK_W'(1);
        on_lvl     = (r_level == '0) ? DUTY_MAX : r_level;
        sum        = $signed({2'b00, r_level}) + (DUTY_W+2)'(r_in_data.delta);

        if (r_in_data.cmd == CMD_TICK) begin
            if (r_mode != RAMP_IDLE) begin
                if (cnt < limit) begin
                    n_tick = cnt;
                end else begin
                    n_tick = '0;
                    if (r_duty < r_target) begin
                        n_duty = r_duty + DUTY_W'(1);
                    end else if (r_duty > r_target) begin
                        n_duty = r_duty - DUTY_W'(1);
                    end
                    check = 1'b1;
                end
            end
        end else if (r_mode == RAMP_IDLE) begin
            unique case (r_in_data.cmd)
                CMD_ON:     go_on  = !r_is_on;
                CMD_OFF:    go_off = r_is_on;
                CMD_TOGGLE: begin
                    go_on  = !r_is_on;
                    go_off = r_is_on;
                end
                CMD_SET: begin
                    if (!r_is_on) begin
                        n_level = r_in_data.level;
                    end else begin
                        n_mode   = RAMP_LEVEL;
                        n_target = r_in_data.level;
                        n_tick   = '0;
                        check    = 1'b1;
                    end
                end
                CMD_ADJUST: begin
                    if (sum < 0) begin
                        n_level = '0;
                    end else if (sum > $signed({2'b00, DUTY_MAX})) begin
                        n_level = DUTY_MAX;
                    end else begin
                        n_level = sum[DUTY_W-1:0];
                    end
                    n_duty  = n_level;
                    n_is_on = (n_level != '0);
                end
                default: ;  // unused codes are ignored
            endcase
            if (go_on) begin
                n_level  = on_lvl;
                n_mode   = RAMP_ON;
                n_target = on_lvl;
                n_tick   = '0;
                check    = 1'b1;
            end
            if (go_off) begin
                n_mode   = RAMP_OFF;
                n_target = '0;
                n_tick   = '0;
                check    = 1'b1;
            end
        end

        // a fade ends the step it lands on target, including a zero-length fade
        if (check && n_mode != RAMP_IDLE && n_duty == n_target) begin
            unique case (n_mode)
                RAMP_ON: begin
                    n_is_on    = 1'b1;
                    n_ev_onoff = 1'b1;
                end
                RAMP_OFF: begin
                    n_is_on    = 1'b0;
                    n_ev_onoff = 1'b1;
                end
                default: begin
                    n_level    = n_target;
                    n_ev_level = 1'b1;
                end
            endcase
            n_mode = RAMP_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_step_ticks <= STEP_TICKS_RST;
            r_duty       <= '0;
            r_level      <= '0;
            r_is_on      <= 1'b0;
            r_target     <= '0;
            r_mode       <= RAMP_IDLE;
            r_tick       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_step_ticks <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_duty      <= n_duty;
                r_level     <= n_level;
                r_is_on     <= n_is_on;
                r_target    <= n_target;
                r_mode      <= n_mode;
                r_tick      <= n_tick;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data.duty         <= n_duty;
            r_out_data.lamp_on      <= n_is_on;
            r_out_data.busy_res     <= (n_mode != RAMP_IDLE);
            r_out_data.onoff_event  <= n_ev_onoff;
            r_out_data.level_event  <= n_ev_level;
            r_out_data.stored_level <= n_level;
        end
    end

endmodule

`default_nettype wire
